// ===== hdl/pbm_pkg.sv =====
`timescale 1ns / 1ps
package pbm_pkg;

  // fixed field widths
  localparam int FUNC_W      = 3;
  localparam int PROTO_W     = 8;
  localparam int PORT_W      = 16;
  localparam int IFACE_W     = 8;
  localparam int IDX_IN_W    = 4;
  localparam int COUNT_OUT_W = 32;

  localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 3'd0,
    FUNC_ADD    = 3'd1,
    FUNC_REMOVE = 3'd2,
    FUNC_CLEAR  = 3'd3,
    FUNC_READ   = 3'd4
  } func_e;

  // classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_NOP,     // rejected or unused code, all result fields zero
    OP_PASS,    // lookup that cannot match, op_ok only
    OP_LOOKUP,
    OP_ADD,
    OP_REMOVE,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY
  } st_e;

  typedef struct packed {
    op_e                 op;
    logic [PORT_W-1:0]   port;
    logic [IFACE_W-1:0]  iface;
    logic                any;
    logic [IDX_IN_W-1:0] index;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_ctl_t;

  typedef struct packed {
    logic                   skip;
    logic                   op_ok;
    logic [IDX_IN_W-1:0]    hit_slot;
    logic                   rd_valid;
    logic [PORT_W-1:0]      rd_port;
    logic [IFACE_W-1:0]     rd_iface;
    logic                   rd_any;
    logic [COUNT_OUT_W-1:0] rd_count;
  } res_t;

endpackage

// ===== hdl/pbm_req_if.sv =====
`timescale 1ns / 1ps
interface pbm_req_if import pbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic                direction;
  logic                is_host;
  logic [PROTO_W-1:0]  protocol;
  logic [PORT_W-1:0]   src_port;
  logic [PORT_W-1:0]   dst_port;
  logic [IFACE_W-1:0]  iface;
  logic                any_iface;
  logic [PORT_W-1:0]   entry_port;
  logic [IDX_IN_W-1:0] entry_index;

  modport source (
    output valid, func, direction, is_host, protocol, src_port, dst_port,
           iface, any_iface, entry_port, entry_index,
    input  ready
  );

  modport sink (
    input  valid, func, direction, is_host, protocol, src_port, dst_port,
           iface, any_iface, entry_port, entry_index,
    output ready
  );
endinterface

// ===== hdl/pbm_rsp_if.sv =====
`timescale 1ns / 1ps
interface pbm_rsp_if import pbm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   skip;
  logic                   op_ok;
  logic [IDX_IN_W-1:0]    hit_slot;
  logic                   rd_valid;
  logic [PORT_W-1:0]      rd_port;
  logic [IFACE_W-1:0]     rd_iface;
  logic                   rd_any;
  logic [COUNT_OUT_W-1:0] rd_count;

  modport source (
    output valid, skip, op_ok, hit_slot, rd_valid, rd_port, rd_iface, rd_any,
           rd_count,
    input  ready
  );

  modport sink (
    input  valid, skip, op_ok, hit_slot, rd_valid, rd_port, rd_iface, rd_any,
           rd_count,
    output ready
  );
endinterface

// ===== hdl/port_bypass_match_table_top.sv =====
// flow: a request transfer enters the command queue; the back end then runs a compare pass
//   and an update pass over the shared slot table and registers the result, taking the next
//   command only after that pass; a 2-deep command queue keeps requests flowing while a result waits
// reset: asynchronous, active low; empties every slot, the command queue and the result register
`timescale 1ns / 1ps
module port_bypass_match_table_top import pbm_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int IFACE_BITS = 8,
  parameter int COUNT_BITS = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  pbm_req_if.sink   req_i,
  pbm_rsp_if.source rsp_o
);

  // front decodes each request transfer into a command
  q_ctl_t q_stat;
  logic   q_push;
  logic   q_pop;
  cmd_t   q_cmd_in;
  cmd_t   q_cmd_out;

  pbm_front u_front (
    .req_i    (req_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .q_cmd_o  (q_cmd_in)
  );

  // short queue decouples request intake from table work
  pbm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd_in),
    .pop_i  (q_pop),
    .stat_o (q_stat),
    .cmd_o  (q_cmd_out)
  );

  // back end owns the table: compare all slots, then update and register the result
  pbm_back #(
    .ENTRIES    (ENTRIES),
    .IFACE_BITS (IFACE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .q_cmd_i  (q_cmd_out),
    .q_pop_o  (q_pop),
    .rsp_o    (rsp_o)
  );

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("command queue push while full");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("command queue pop while empty");

  // queued commands are not lost without a pop
  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_stat.empty && !q_pop) |=> !q_stat.empty)
    else $error("command queue drained without a pop");

  // request side ready follows queue space only
  a_ready_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready == !q_stat.full)
    else $error("request ready disagrees with queue space");

endmodule

// ===== hdl/pbm_front.sv =====
`timescale 1ns / 1ps
module pbm_front import pbm_pkg::*; (
  pbm_req_if.sink req_i,
  input  q_ctl_t  q_stat_i,
  output logic    q_push_o,
  output cmd_t    q_cmd_o
);

  func_e func_s;

  assign func_s   = func_e'(req_i.func);
  assign req_i.ready = !q_stat_i.full;
  assign q_push_o = req_i.valid && !q_stat_i.full;

  always_comb begin
    q_cmd_o    = '0;
    q_cmd_o.op = OP_NOP;
    unique case (func_s) inside
      FUNC_LOOKUP: begin
        if (req_i.is_host && req_i.protocol == PROTO_TCP) begin
          q_cmd_o.op    = OP_LOOKUP;
          q_cmd_o.port  = req_i.direction ? req_i.src_port : req_i.dst_port;
          q_cmd_o.iface = req_i.iface;
        end else begin
          q_cmd_o.op = OP_PASS;
        end
      end
      FUNC_ADD, FUNC_REMOVE: begin
        // port zero marks empty and is never an entry
        if (req_i.entry_port != '0) begin
          q_cmd_o.op    = (func_s == FUNC_ADD) ? OP_ADD : OP_REMOVE;
          q_cmd_o.port  = req_i.entry_port;
          q_cmd_o.iface = req_i.any_iface ? '0 : req_i.iface;
          q_cmd_o.any   = req_i.any_iface;
        end
      end
      FUNC_CLEAR: q_cmd_o.op = OP_CLEAR;
      FUNC_READ: begin
        q_cmd_o.op    = OP_READ;
        q_cmd_o.index = req_i.entry_index;
      end
      default: q_cmd_o.op = OP_NOP;
    endcase
  end

endmodule

// ===== hdl/pbm_queue.sv =====
`timescale 1ns / 1ps
module pbm_queue import pbm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  cmd_t   cmd_i,
  input  logic   pop_i,
  output q_ctl_t stat_o,
  output cmd_t   cmd_o
);

  cmd_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign cmd_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hdl/pbm_back.sv =====
`timescale 1ns / 1ps
module pbm_back import pbm_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int IFACE_BITS = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  q_ctl_t q_stat_i,
  input  cmd_t   q_cmd_i,
  output logic   q_pop_o,
  pbm_rsp_if.source rsp_o
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // table
  logic [PORT_W-1:0]     port_q  [ENTRIES];
  logic [PORT_W-1:0]     port_d  [ENTRIES];
  logic [IFACE_BITS-1:0] iface_q [ENTRIES];
  logic [IFACE_BITS-1:0] iface_d [ENTRIES];
  logic                  any_q   [ENTRIES];
  logic                  any_d   [ENTRIES];
  logic [COUNT_BITS-1:0] hits_q  [ENTRIES];
  logic [COUNT_BITS-1:0] hits_d  [ENTRIES];

  // table shifted down by one, last slot empty
  logic [PORT_W-1:0]     up_port  [ENTRIES];
  logic [IFACE_BITS-1:0] up_iface [ENTRIES];
  logic                  up_any   [ENTRIES];
  logic [COUNT_BITS-1:0] up_hits  [ENTRIES];

  st_e  st_q, st_d;
  cmd_t cmd_q;
  logic out_free, apply_en, match_en;

  logic [ENTRIES-1:0] sel_vec, empty_vec;
  logic               found_s, has_empty_s;
  logic [IDX_W-1:0]   idx_s, eidx_s;
  logic               found_q, has_empty_q;
  logic [IDX_W-1:0]   idx_q, eidx_q;

  logic [IFACE_W+IFACE_BITS-1:0] key_ext;
  logic [IFACE_BITS-1:0]         key_if;

  logic                          in_range;
  logic [IDX_IN_W+IDX_W-1:0]     rsel_ext;
  logic [IDX_W-1:0]              rsel;
  logic [IDX_IN_W+IDX_W-1:0]     hit_ext;
  logic [IFACE_W+IFACE_BITS-1:0] rd_if_ext;
  logic [COUNT_OUT_W+COUNT_BITS-1:0] rd_cnt_ext;

  logic res_valid_q;
  res_t res_q, res_d;

  assign out_free = !res_valid_q || rsp_o.ready;

  // sequencer: match pass, then update pass
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:  if (!q_stat_i.empty) st_d = ST_MATCH;
      ST_MATCH: st_d = ST_APPLY;
      ST_APPLY: if (out_free) st_d = q_stat_i.empty ? ST_IDLE : ST_MATCH;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    apply_en = 1'b0;
    match_en = 1'b0;
    unique case (st_q)
      ST_IDLE:  q_pop_o = !q_stat_i.empty;
      ST_MATCH: match_en = 1'b1;
      ST_APPLY: begin
        apply_en = out_free;
        q_pop_o  = out_free && !q_stat_i.empty;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cmd_q <= q_cmd_i;
  end

  // parallel compare over all slots
  assign key_ext = {{IFACE_BITS{1'b0}}, cmd_q.iface};
  assign key_if  = key_ext[IFACE_BITS-1:0];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      empty_vec[i] = (port_q[i] == '0);
      if (cmd_q.op == OP_LOOKUP) begin
        sel_vec[i] = !empty_vec[i] && port_q[i] == cmd_q.port &&
                     (any_q[i] || iface_q[i] == key_if);
      end else begin
        sel_vec[i] = port_q[i] == cmd_q.port &&
                     ((any_q[i] || cmd_q.any) ? (any_q[i] && cmd_q.any)
                                              : (iface_q[i] == key_if));
      end
    end
  end

  // first set bit wins
  always_comb begin
    found_s     = 1'b0;
    idx_s       = '0;
    has_empty_s = 1'b0;
    eidx_s      = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (sel_vec[i]) begin
        found_s = 1'b1;
        idx_s   = IDX_W'(i);
      end
      if (empty_vec[i]) begin
        has_empty_s = 1'b1;
        eidx_s      = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (match_en) begin
      found_q     <= found_s;
      idx_q       <= idx_s;
      has_empty_q <= has_empty_s;
      eidx_q      <= eidx_s;
    end
  end

  always_comb begin
    for (int j = 0; j < ENTRIES - 1; j++) begin
      up_port[j]  = port_q[j+1];
      up_iface[j] = iface_q[j+1];
      up_any[j]   = any_q[j+1];
      up_hits[j]  = hits_q[j+1];
    end
    up_port[ENTRIES-1]  = '0;
    up_iface[ENTRIES-1] = '0;
    up_any[ENTRIES-1]   = 1'b0;
    up_hits[ENTRIES-1]  = '0;
  end

  // table update
  always_comb begin
    port_d  = port_q;
    iface_d = iface_q;
    any_d   = any_q;
    hits_d  = hits_q;
    if (apply_en) begin
      case (cmd_q.op)
        OP_LOOKUP: begin
          if (found_q) hits_d[idx_q] = hits_q[idx_q] + COUNT_BITS'(1);
        end
        OP_ADD: begin
          if (!found_q && has_empty_q) begin
            port_d[eidx_q]  = cmd_q.port;
            iface_d[eidx_q] = key_if;
            any_d[eidx_q]   = cmd_q.any;
            hits_d[eidx_q]  = '0;
          end
        end
        OP_REMOVE: begin
          if (found_q) begin
            for (int j = 0; j < ENTRIES; j++) begin
              if (IDX_W'(j) >= idx_q) begin
                port_d[j]  = up_port[j];
                iface_d[j] = up_iface[j];
                any_d[j]   = up_any[j];
                hits_d[j]  = up_hits[j];
              end
            end
          end
        end
        OP_CLEAR: begin
          for (int j = 0; j < ENTRIES; j++) begin
            port_d[j]  = '0;
            iface_d[j] = '0;
            any_d[j]   = 1'b0;
            hits_d[j]  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ENTRIES; j++) begin
        port_q[j]  <= '0;
        iface_q[j] <= '0;
        any_q[j]   <= 1'b0;
        hits_q[j]  <= '0;
      end
    end else begin
      port_q  <= port_d;
      iface_q <= iface_d;
      any_q   <= any_d;
      hits_q  <= hits_d;
    end
  end

  // result
  assign in_range   = (int'(cmd_q.index) < ENTRIES);
  assign rsel_ext   = {{IDX_W{1'b0}}, cmd_q.index};
  assign rsel       = rsel_ext[IDX_W-1:0];
  assign hit_ext    = {{IDX_IN_W{1'b0}}, idx_q};
  assign rd_if_ext  = {{IFACE_W{1'b0}}, iface_q[rsel]};
  assign rd_cnt_ext = {{COUNT_OUT_W{1'b0}}, hits_q[rsel]};

  always_comb begin
    res_d = '0;
    case (cmd_q.op)
      OP_PASS:   res_d.op_ok = 1'b1;
      OP_LOOKUP: begin
        res_d.op_ok = 1'b1;
        if (found_q) begin
          res_d.skip     = 1'b1;
          res_d.hit_slot = hit_ext[IDX_IN_W-1:0];
        end
      end
      OP_ADD:    res_d.op_ok = found_q || has_empty_q;
      OP_REMOVE: res_d.op_ok = found_q;
      OP_CLEAR:  res_d.op_ok = 1'b1;
      OP_READ: begin
        res_d.op_ok = 1'b1;
        if (in_range) begin
          res_d.rd_valid = (port_q[rsel] != '0);
          res_d.rd_port  = port_q[rsel];
          res_d.rd_iface = rd_if_ext[IFACE_W-1:0];
          res_d.rd_any   = any_q[rsel];
          res_d.rd_count = rd_cnt_ext[COUNT_OUT_W-1:0];
        end
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (apply_en) begin
      res_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_en) res_q <= res_d;
  end

  assign rsp_o.valid    = res_valid_q;
  assign rsp_o.skip     = res_q.skip;
  assign rsp_o.op_ok    = res_q.op_ok;
  assign rsp_o.hit_slot = res_q.hit_slot;
  assign rsp_o.rd_valid = res_q.rd_valid;
  assign rsp_o.rd_port  = res_q.rd_port;
  assign rsp_o.rd_iface = res_q.rd_iface;
  assign rsp_o.rd_any   = res_q.rd_any;
  assign rsp_o.rd_count = res_q.rd_count;

endmodule

// ===== verif/tb_port_bypass_match_table_top.sv =====
`timescale 1ns / 1ps
module tb_port_bypass_match_table_top import pbm_pkg::*; ();

  // table depth and run shape
  localparam int SLOTS        = 16;
  localparam int RANDOM_ITEMS = 1700;
  localparam int IDLE_PCT     = 16;
  localparam int QUIET_FROM   = 900;
  localparam int QUIET_TO     = 1200;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 2000;
  localparam int SHOWN_ERRORS = 10;

  // func codes with no operation behind them
  localparam logic [FUNC_W-1:0] FUNC_RSVD_LO  = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_MID = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_HI  = 3'd7;

  // one request as it crosses the input channel
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic                direction;
    logic                is_host;
    logic [PROTO_W-1:0]  protocol;
    logic [PORT_W-1:0]   src_port;
    logic [PORT_W-1:0]   dst_port;
    logic [IFACE_W-1:0]  iface;
    logic                any_iface;
    logic [PORT_W-1:0]   entry_port;
    logic [IDX_IN_W-1:0] entry_index;
  } req_item_t;

  // shadow copy of the bypass table plus the results still owed by the block
  class bypass_table_sb;
    logic [PORT_W-1:0]      slot_port [SLOTS];
    logic [IFACE_W-1:0]     slot_iface[SLOTS];
    logic                   slot_any  [SLOTS];
    logic [COUNT_OUT_W-1:0] slot_hits [SLOTS];
    res_t                   owed_results[$];
    int                     mismatches;

    function new();
      mismatches = 0;
      clear_slots();
    endfunction

    function void clear_slots();
      for (int i = 0; i < SLOTS; i++) begin
        slot_port[i]  = '0;
        slot_iface[i] = '0;
        slot_any[i]   = 1'b0;
        slot_hits[i]  = '0;
      end
    endfunction

    // same port, and both any-marked or both bound to the same interface
    function bit same_entry(int i, logic [PORT_W-1:0] port, logic [IFACE_W-1:0] ifc,
                            logic any);
      if (slot_port[i] != port) return 1'b0;
      if (slot_any[i] || any) return slot_any[i] && any;
      return slot_iface[i] == ifc;
    endfunction

    function res_t predict_result(req_item_t rq);
      res_t              r;
      logic [PORT_W-1:0] key;
      logic [IFACE_W-1:0] ifc;
      bit                done;
      r    = '0;
      done = 1'b0;
      // an any-marked entry is stored with interface zero
      ifc  = rq.any_iface ? '0 : rq.iface;
      case (rq.func)
        FUNC_LOOKUP: begin
          r.op_ok = 1'b1;
          key = rq.direction ? rq.src_port : rq.dst_port;
          if (rq.is_host && rq.protocol == PROTO_TCP) begin
            for (int i = 0; i < SLOTS && !done; i++) begin
              if (slot_port[i] == '0) begin
                done = 1'b1;
              end else if (slot_port[i] == key && (slot_any[i] || slot_iface[i] == rq.iface)) begin
                slot_hits[i] = slot_hits[i] + 1'b1;
                r.skip       = 1'b1;
                r.hit_slot   = IDX_IN_W'(i);
                done         = 1'b1;
              end
            end
          end
        end
        FUNC_ADD: begin
          if (rq.entry_port != '0) begin
            for (int i = 0; i < SLOTS && !done; i++) begin
              if (slot_port[i] == '0) begin
                slot_port[i]  = rq.entry_port;
                slot_iface[i] = ifc;
                slot_any[i]   = rq.any_iface;
                slot_hits[i]  = '0;
                r.op_ok       = 1'b1;
                done          = 1'b1;
              end else if (same_entry(i, rq.entry_port, ifc, rq.any_iface)) begin
                r.op_ok = 1'b1;
                done    = 1'b1;
              end
            end
          end
        end
        FUNC_REMOVE: begin
          if (rq.entry_port != '0) begin
            for (int i = 0; i < SLOTS && !done; i++) begin
              if (slot_port[i] == '0) begin
                done = 1'b1;
              end else if (same_entry(i, rq.entry_port, ifc, rq.any_iface)) begin
                for (int j = i; j < SLOTS - 1; j++) begin
                  slot_port[j]  = slot_port[j+1];
                  slot_iface[j] = slot_iface[j+1];
                  slot_any[j]   = slot_any[j+1];
                  slot_hits[j]  = slot_hits[j+1];
                end
                slot_port[SLOTS-1]  = '0;
                slot_iface[SLOTS-1] = '0;
                slot_any[SLOTS-1]   = 1'b0;
                slot_hits[SLOTS-1]  = '0;
                r.op_ok = 1'b1;
                done    = 1'b1;
              end
            end
          end
        end
        FUNC_CLEAR: begin
          clear_slots();
          r.op_ok = 1'b1;
        end
        FUNC_READ: begin
          r.op_ok    = 1'b1;
          r.rd_valid = slot_port[rq.entry_index] != '0;
          r.rd_port  = slot_port[rq.entry_index];
          r.rd_iface = slot_iface[rq.entry_index];
          r.rd_any   = slot_any[rq.entry_index];
          r.rd_count = slot_hits[rq.entry_index];
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(req_item_t rq);
      owed_results.push_back(predict_result(rq));
    endfunction

    function string show_result(res_t r);
      return $sformatf("skip=%0b ok=%0b slot=%0d rdv=%0b port=%0d iface=%0d any=%0b cnt=%0d",
                       r.skip, r.op_ok, r.hit_slot, r.rd_valid, r.rd_port, r.rd_iface,
                       r.rd_any, r.rd_count);
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) $display("%s", msg);
    endfunction

    function void check_result(res_t got);
      res_t  want;
      string bad;
      if (owed_results.size() == 0) begin
        note_failure({"result with none outstanding: ", show_result(got)});
        return;
      end
      want = owed_results.pop_front();
      bad  = "";
      if (got.skip     !== want.skip)     bad = {bad, " skip"};
      if (got.op_ok    !== want.op_ok)    bad = {bad, " op_ok"};
      if (got.hit_slot !== want.hit_slot) bad = {bad, " hit_slot"};
      if (got.rd_valid !== want.rd_valid) bad = {bad, " rd_valid"};
      if (got.rd_port  !== want.rd_port)  bad = {bad, " rd_port"};
      if (got.rd_iface !== want.rd_iface) bad = {bad, " rd_iface"};
      if (got.rd_any   !== want.rd_any)   bad = {bad, " rd_any"};
      if (got.rd_count !== want.rd_count) bad = {bad, " rd_count"};
      if (bad != "") begin
        note_failure($sformatf("mismatch on%s at %0t\n  exp %s\n  got %s", bad, $realtime,
                               show_result(want), show_result(got)));
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pbm_req_if req_if ();
  pbm_rsp_if rsp_if ();

  port_bypass_match_table_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  bypass_table_sb sb;
  int             n_accepted;
  req_item_t      seen_req;
  res_t           seen_rsp;

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // no idling on either side while this many transfers have gone by
  function automatic bit in_quiet_window();
    return n_accepted >= QUIET_FROM && n_accepted < QUIET_TO;
  endfunction

  // ------------------------------------------------------------------
  // stimulus builders
  // ------------------------------------------------------------------

  // every field random, so unused fields still toggle, then the op code
  function automatic req_item_t op_item(logic [FUNC_W-1:0] func);
    req_item_t it;
    it.func        = func;
    it.direction   = 1'($urandom_range(1));
    it.is_host     = 1'($urandom_range(1));
    it.protocol    = PROTO_W'($urandom_range(255));
    it.src_port    = PORT_W'($urandom_range(65535));
    it.dst_port    = PORT_W'($urandom_range(65535));
    it.iface       = IFACE_W'($urandom_range(255));
    it.any_iface   = 1'($urandom_range(1));
    it.entry_port  = PORT_W'($urandom_range(65535));
    it.entry_index = IDX_IN_W'($urandom_range(15));
    return it;
  endfunction

  function automatic req_item_t lookup_item(logic dir, logic host, logic [PROTO_W-1:0] proto,
                                            logic [PORT_W-1:0] sport, logic [PORT_W-1:0] dport,
                                            logic [IFACE_W-1:0] ifc);
    req_item_t it;
    it           = op_item(FUNC_LOOKUP);
    it.direction = dir;
    it.is_host   = host;
    it.protocol  = proto;
    it.src_port  = sport;
    it.dst_port  = dport;
    it.iface     = ifc;
    return it;
  endfunction

  function automatic req_item_t edit_item(logic [FUNC_W-1:0] func, logic [PORT_W-1:0] port,
                                          logic [IFACE_W-1:0] ifc, logic any);
    req_item_t it;
    it            = op_item(func);
    it.entry_port = port;
    it.iface      = ifc;
    it.any_iface  = any;
    return it;
  endfunction

  function automatic req_item_t read_item(logic [IDX_IN_W-1:0] idx);
    req_item_t it;
    it             = op_item(FUNC_READ);
    it.entry_index = idx;
    return it;
  endfunction

  // small pool so that adds collide, removes find entries and lookups hit
  function automatic logic [PORT_W-1:0] pick_port();
    if ($urandom_range(99) >= 88) return PORT_W'($urandom_range(65535));
    case ($urandom_range(11))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd22;
      3:       return 16'd80;
      4:       return 16'd443;
      5:       return 16'd8080;
      6:       return 16'hffff;
      7:       return 16'h8000;
      8:       return 16'h7fff;
      9:       return 16'd3;
      10:      return 16'd5;
      default: return 16'd53;
    endcase
  endfunction

  function automatic logic [IFACE_W-1:0] pick_iface();
    if ($urandom_range(99) < 80) return IFACE_W'($urandom_range(3));
    return IFACE_W'($urandom_range(255));
  endfunction

  // lookups of live traffic as the largest share, a steady flow of table edits, some noise
  function automatic req_item_t random_request();
    int                roll;
    logic              dir;
    logic [PORT_W-1:0] key;
    logic [PORT_W-1:0] other;
    roll = $urandom_range(99);
    if (roll < 45) begin
      dir   = 1'($urandom_range(1));
      key   = pick_port();
      other = pick_port();
      return lookup_item(dir, $urandom_range(99) < 90,
                         ($urandom_range(99) < 85) ? PROTO_TCP : PROTO_W'($urandom_range(255)),
                         dir ? key : other, dir ? other : key, pick_iface());
    end
    if (roll < 70) return edit_item(FUNC_ADD, pick_port(), pick_iface(), $urandom_range(99) < 30);
    if (roll < 82) return edit_item(FUNC_REMOVE, pick_port(), pick_iface(),
                                    $urandom_range(99) < 30);
    if (roll < 95) return read_item(IDX_IN_W'($urandom_range(15)));
    if (roll < 97) return op_item(FUNC_CLEAR);
    return op_item(FUNC_W'($urandom_range(5, 7)));
  endfunction

  // ------------------------------------------------------------------
  // request side driver
  // ------------------------------------------------------------------

  // random gaps before the item, then hold it until the transfer
  task automatic push_request(input req_item_t it);
    while (!in_quiet_window() && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.func        <= it.func;
    req_if.direction   <= it.direction;
    req_if.is_host     <= it.is_host;
    req_if.protocol    <= it.protocol;
    req_if.src_port    <= it.src_port;
    req_if.dst_port    <= it.dst_port;
    req_if.iface       <= it.iface;
    req_if.any_iface   <= it.any_iface;
    req_if.entry_port  <= it.entry_port;
    req_if.entry_index <= it.entry_index;
    req_if.valid       <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // ------------------------------------------------------------------
  // response side: random stalls, a quiet stretch, and one long hold-off
  // that backs the block up into its input
  // ------------------------------------------------------------------
  initial begin : rsp_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= in_quiet_window() || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ------------------------------------------------------------------
  // monitors: values sampled at the edge are the ones before it
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        seen_req.func        = req_if.func;
        seen_req.direction   = req_if.direction;
        seen_req.is_host     = req_if.is_host;
        seen_req.protocol    = req_if.protocol;
        seen_req.src_port    = req_if.src_port;
        seen_req.dst_port    = req_if.dst_port;
        seen_req.iface       = req_if.iface;
        seen_req.any_iface   = req_if.any_iface;
        seen_req.entry_port  = req_if.entry_port;
        seen_req.entry_index = req_if.entry_index;
        sb.note_request(seen_req);
        n_accepted++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        seen_rsp.skip     = rsp_if.skip;
        seen_rsp.op_ok    = rsp_if.op_ok;
        seen_rsp.hit_slot = rsp_if.hit_slot;
        seen_rsp.rd_valid = rsp_if.rd_valid;
        seen_rsp.rd_port  = rsp_if.rd_port;
        seen_rsp.rd_iface = rsp_if.rd_iface;
        seen_rsp.rd_any   = rsp_if.rd_any;
        seen_rsp.rd_count = rsp_if.rd_count;
        sb.check_result(seen_rsp);
      end
    end
  end

  // watchdog: too many cycles in a row with no transfer on either side
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !rst_ni)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("stalled for %0d cycles with %0d results outstanding", STALL_LIMIT, sb.pending());
    $display("Regression FAIL");
    $finish;
  end

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin : main_seq
    sb         = new();
    n_accepted = 0;
    rst_ni     = 1'b0;
    req_if.valid       <= 1'b0;
    req_if.func        <= '0;
    req_if.direction   <= 1'b0;
    req_if.is_host     <= 1'b0;
    req_if.protocol    <= '0;
    req_if.src_port    <= '0;
    req_if.dst_port    <= '0;
    req_if.iface       <= '0;
    req_if.any_iface   <= 1'b0;
    req_if.entry_port  <= '0;
    req_if.entry_index <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table after reset: reads of both ends and a lookup that finds nothing
    push_request(read_item(4'd0));
    push_request(read_item(4'd15));
    push_request(lookup_item(1'b0, 1'b1, PROTO_TCP, 16'd1, 16'd80, 8'd0));
    // port zero is refused by add and remove
    push_request(edit_item(FUNC_ADD, 16'd0, 8'd1, 1'b0));
    push_request(edit_item(FUNC_REMOVE, 16'd0, 8'd1, 1'b0));
    // remove of an entry that is not there
    push_request(edit_item(FUNC_REMOVE, 16'd22, 8'd1, 1'b0));
    // unused op codes leave everything zero
    push_request(op_item(FUNC_RSVD_LO));
    push_request(op_item(FUNC_RSVD_MID));
    push_request(op_item(FUNC_RSVD_HI));
    // extreme port and interface, then an any-interface entry stored with interface zero
    push_request(edit_item(FUNC_ADD, 16'hffff, 8'hff, 1'b0));
    push_request(edit_item(FUNC_ADD, 16'd80, 8'd7, 1'b1));
    // duplicate any-interface entry is present already, a bound one is distinct
    push_request(edit_item(FUNC_ADD, 16'd80, 8'd3, 1'b1));
    push_request(edit_item(FUNC_ADD, 16'd80, 8'd5, 1'b0));
    // input lookup on dest port hits the any entry, output lookup on source port
    push_request(lookup_item(1'b0, 1'b1, PROTO_TCP, 16'hffff, 16'd80, 8'd9));
    push_request(lookup_item(1'b1, 1'b1, PROTO_TCP, 16'hffff, 16'd80, 8'hff));
    // not for this host, not tcp, port zero: none may match
    push_request(lookup_item(1'b1, 1'b0, PROTO_TCP, 16'hffff, 16'd80, 8'hff));
    push_request(lookup_item(1'b1, 1'b1, 8'hff, 16'hffff, 16'd80, 8'hff));
    push_request(lookup_item(1'b0, 1'b1, PROTO_TCP, 16'hffff, 16'd0, 8'd0));
    push_request(read_item(4'd0));
    // remove from the front shifts the rest down and clears the tail
    push_request(edit_item(FUNC_REMOVE, 16'hffff, 8'hff, 1'b0));
    push_request(read_item(4'd0));
    push_request(read_item(4'd2));
    push_request(op_item(FUNC_CLEAR));
    push_request(read_item(4'd0));

    // random traffic
    for (int n = 0; n < RANDOM_ITEMS; n++) push_request(random_request());
    req_if.valid <= 1'b0;

    // drain, then keep watching for anything stray
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pbm_pkg.sv
hdl/pbm_req_if.sv
hdl/pbm_rsp_if.sv
hdl/pbm_front.sv
hdl/pbm_queue.sv
hdl/pbm_back.sv
hdl/port_bypass_match_table_top.sv
verif/tb_port_bypass_match_table_top.sv
